/* hw/rtl/ray_sphere_intersect_assert.svh */
// assertion macros for the ray-sphere intersection block
`ifndef RAY_SPHERE_INTERSECT_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RSI_ASSERT_NOW(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("rsi: same-cycle check failed");

// next-cycle implication
`define RSI_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("rsi: next-cycle check failed");

`endif

/* hw/rtl/rsi_pkg.sv */
// shared widths, types and constants of the ray-sphere intersection block
package rsi_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned DIR_W   = 16;
  localparam int unsigned RAD_W   = 23;
  localparam int unsigned DIST_W  = 26;
  localparam int unsigned LIM_W   = 8;
  localparam int unsigned T1_W    = 28;
  localparam int unsigned T2_W    = 58;
  localparam int unsigned ROOT_W  = T2_W / 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [LIM_W-1:0] NEAR_ZERO_RESET = LIM_W'(1);
  localparam logic             REG_NEAR_ZERO   = 1'b0;

  // sideband that travels alongside the square root
  typedef struct packed {
    logic            enclosed;
    logic            ok;
    logic [T1_W-1:0] t1;
  } tag_t;

endpackage

/* hw/rtl/ray_sphere_intersect.sv */
// ray-sphere intersection top level: geometry pipeline, square root and output register
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   in_      | in_valid / in_ready    | origin, direction, centre, radius
//   out_     | out_valid / out_ready  | hit, hit_distance
//   cfg_     | apb, pready tied high  | near_zero_limit at byte address 0
//
// one transaction per cycle sustained while out_ready is high; the path is 6 geometry stages, 29 square
// root stages (one root bit each) and the output register.
// rst_n is synchronous; it clears the valid bits and sets near_zero_limit to 1.
// every full stage holds while the one after it is full and stalled, so bubbles
// close up and nothing is dropped or repeated.
module ray_sphere_intersect #(
  parameter int unsigned RootW = rsi_pkg::ROOT_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_x,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_y,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_origin_z,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_x,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_y,
  input  logic signed [rsi_pkg::DIR_W-1:0]  in_dir_z,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_center_x,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_center_y,
  input  logic signed [rsi_pkg::POS_W-1:0]  in_center_z,
  input  logic        [rsi_pkg::RAD_W-1:0]  in_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic        [rsi_pkg::DIST_W-1:0] out_hit_distance,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic        [rsi_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic        [rsi_pkg::DATA_W-1:0] cfg_pwdata,
  output logic        [rsi_pkg::DATA_W-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  `include "ray_sphere_intersect_assert.svh"

  localparam int unsigned T1W = rsi_pkg::T1_W;
  localparam int unsigned T2W = 2 * RootW;
  localparam int unsigned LW  = rsi_pkg::LIM_W;

  // configuration
  logic [LW-1:0] lim_r;
  logic          cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[rsi_pkg::ADDR_W-1] == rsi_pkg::REG_NEAR_ZERO);
  assign cfg_prdata = (cfg_paddr[rsi_pkg::ADDR_W-1] == rsi_pkg::REG_NEAR_ZERO) ?
                      rsi_pkg::DATA_W'(lim_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= rsi_pkg::NEAR_ZERO_RESET;
    end else if (cfg_wr) begin
      lim_r <= cfg_pwdata[LW-1:0];
    end
  end

  // stage valid bits and advance chain
  logic [6:1] v_r;
  logic [7:1] adv;
  logic       sq_in_ready;

  always_comb begin
    adv[7] = sq_in_ready;
    for (int k = 6; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end
  assign in_ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (adv[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: centre minus origin
  logic signed [24:0] dx1_r, dy1_r, dz1_r;
  logic signed [15:0] ux1_r, uy1_r, uz1_r;
  logic        [22:0] r1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      dx1_r <= $signed({in_center_x[23], in_center_x}) - $signed({in_origin_x[23], in_origin_x});
      dy1_r <= $signed({in_center_y[23], in_center_y}) - $signed({in_origin_y[23], in_origin_y});
      dz1_r <= $signed({in_center_z[23], in_center_z}) - $signed({in_origin_z[23], in_origin_z});
      ux1_r <= in_dir_x;
      uy1_r <= in_dir_y;
      uz1_r <= in_dir_z;
      r1_r  <= in_radius;
    end
  end

  // stage 2: products
  logic signed [49:0] sqx, sqy, sqz;
  logic signed [40:0] px_nxt, py_nxt, pz_nxt;
  logic        [48:0] sqx2_r, sqy2_r, sqz2_r;
  logic signed [40:0] px2_r, py2_r, pz2_r;
  logic        [45:0] rsq2_r;

  assign sqx    = dx1_r * dx1_r;
  assign sqy    = dy1_r * dy1_r;
  assign sqz    = dz1_r * dz1_r;
  assign px_nxt = dx1_r * ux1_r;
  assign py_nxt = dy1_r * uy1_r;
  assign pz_nxt = dz1_r * uz1_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sqx2_r <= sqx[48:0];
      sqy2_r <= sqy[48:0];
      sqz2_r <= sqz[48:0];
      px2_r  <= px_nxt;
      py2_r  <= py_nxt;
      pz2_r  <= pz_nxt;
      rsq2_r <= r1_r * r1_r;
    end
  end

  // stage 3: sums
  logic        [49:0] dsq3_r;
  logic signed [42:0] dot3_r;
  logic        [45:0] rsq3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      dsq3_r <= 50'(sqx2_r) + 50'(sqy2_r) + 50'(sqz2_r);
      dot3_r <= 43'(px2_r) + 43'(py2_r) + 43'(pz2_r);
      rsq3_r <= rsq2_r;
    end
  end

  // stage 4: inside test, t1 and its limit check
  logic [T1W-1:0]     t1_nxt;
  logic [T1W-1:0]     t14_r;
  logic signed [50:0] diff4_r;
  logic               inside4_r, miss4_r;

  assign t1_nxt = dot3_r[41:14];

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      t14_r     <= t1_nxt;
      diff4_r   <= $signed({1'b0, 50'(rsq3_r)}) - $signed({1'b0, dsq3_r});
      inside4_r <= dsq3_r < 50'(rsq3_r);
      // pointing away or projection too small
      miss4_r   <= dot3_r[42] || (t1_nxt < T1W'(lim_r));
    end
  end

  // stage 5: t1 squared
  logic [T1W-1:0]     t15_r;
  logic [2*T1W-1:0]   t1sq5_r;
  logic signed [50:0] diff5_r;
  logic               inside5_r, miss5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      t15_r     <= t14_r;
      t1sq5_r   <= t14_r * t14_r;
      diff5_r   <= diff4_r;
      inside5_r <= inside4_r;
      miss5_r   <= miss4_r;
    end
  end

  // stage 6: t2 squared and its limit check
  logic signed [T2W-1:0] t2_nxt;
  logic [T2W-1:0]        rad6_r;
  rsi_pkg::tag_t         tag6_r;

  assign t2_nxt = T2W'(diff5_r) + $signed({2'b00, t1sq5_r});

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      rad6_r          <= t2_nxt;
      tag6_r.enclosed <= inside5_r;
      tag6_r.ok       <= !inside5_r && !miss5_r &&
                         !(t2_nxt < $signed({(T2W-LW)'(0), lim_r}));
      tag6_r.t1       <= t15_r;
    end
  end

  // square root
  logic             sq_out_valid;
  logic             sq_out_ready;
  logic [RootW-1:0] sq_root;
  rsi_pkg::tag_t    sq_tag;

  rsi_isqrt #(
    .RootW (RootW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_r[6]),
    .in_ready  (sq_in_ready),
    .in_rad    (rad6_r),
    .in_tag    (tag6_r),
    .out_valid (sq_out_valid),
    .out_ready (sq_out_ready),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  // output register: distance with saturation
  localparam int unsigned SubW = (T1W > RootW ? T1W : RootW) + 1;
  logic [SubW-1:0]             dist_full;
  logic [rsi_pkg::DIST_W-1:0]  dist_sat;
  logic                        out_valid_r;
  logic                        hit_r;
  logic [rsi_pkg::DIST_W-1:0]  dist_r;

  assign dist_full = SubW'(sq_tag.t1) - SubW'(sq_root);
  assign dist_sat  = (dist_full > SubW'({rsi_pkg::DIST_W{1'b1}})) ?
                     {rsi_pkg::DIST_W{1'b1}} : dist_full[rsi_pkg::DIST_W-1:0];
  assign sq_out_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sq_out_ready) begin
      out_valid_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_out_ready) begin
      hit_r  <= sq_tag.enclosed || sq_tag.ok;
      dist_r <= sq_tag.ok ? dist_sat : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = hit_r;
  assign out_hit_distance = dist_r;

  `RSI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_hit_distance == '0)
  `RSI_ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_wr, lim_r == $past(cfg_pwdata[LW-1:0]))
  `RSI_ASSERT_NOW(a_stall_full, clk, rst_n, !in_ready, v_r[1] && !adv[2])

endmodule

/* hw/rtl/rsi_isqrt.sv */
// pipelined floor integer square root, one result bit per stage
module rsi_isqrt #(
  parameter int unsigned RootW = rsi_pkg::ROOT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2*RootW-1:0]     in_rad,
  input  rsi_pkg::tag_t          in_tag,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [RootW-1:0]       out_root,
  output rsi_pkg::tag_t          out_tag
);

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 3;

  logic                v_r    [RootW];
  logic [RemW-1:0]     rem_r  [RootW];
  logic [RootW-1:0]    root_r [RootW];
  logic [RadW-1:0]     rad_r  [RootW];
  rsi_pkg::tag_t       tag_r  [RootW];
  logic [RootW:0]      adv;

  assign adv[RootW] = out_ready;

  genvar i;
  generate
    for (i = 0; i < RootW; i++) begin : g_stage
      logic             v_in;
      logic [RemW-1:0]  rem_in;
      logic [RootW-1:0] root_in;
      logic [RadW-1:0]  rad_in;
      rsi_pkg::tag_t    tag_in;
      logic [RemW-1:0]  rem_sh;
      logic [RemW-1:0]  trial;
      logic             take;

      if (i == 0) begin : g_first
        assign v_in    = in_valid;
        assign rem_in  = '0;
        assign root_in = '0;
        assign rad_in  = in_rad;
        assign tag_in  = in_tag;
      end else begin : g_rest
        assign v_in    = v_r[i-1];
        assign rem_in  = rem_r[i-1];
        assign root_in = root_r[i-1];
        assign rad_in  = rad_r[i-1];
        assign tag_in  = tag_r[i-1];
      end

      assign adv[i] = !v_r[i] || adv[i+1];
      // bring down the next two radicand bits and try (4*root + 1)
      assign rem_sh = {rem_in[RemW-3:0], rad_in[RadW-1:RadW-2]};
      assign trial  = RemW'({root_in, 2'b01});
      assign take   = rem_sh >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[i] <= 1'b0;
        end else if (adv[i]) begin
          v_r[i] <= v_in;
        end
      end

      always_ff @(posedge clk) begin
        if (adv[i]) begin
          rem_r[i]  <= take ? rem_sh - trial : rem_sh;
          root_r[i] <= {root_in[RootW-2:0], take};
          rad_r[i]  <= {rad_in[RadW-3:0], 2'b00};
          tag_r[i]  <= tag_in;
        end
      end
    end
  endgenerate

  assign in_ready  = adv[0];
  assign out_valid = v_r[RootW-1];
  assign out_root  = root_r[RootW-1];
  assign out_tag   = tag_r[RootW-1];

endmodule

/* sim/ray_sphere_intersect_test.sv */
// testbench for the ray-sphere intersection block: directed and random rays against a predictor
module ray_sphere_intersect_test;

  localparam logic [rsi_pkg::ADDR_W-1:0] ADDR_NEAR_ZERO =
    rsi_pkg::ADDR_W'(4 * rsi_pkg::REG_NEAR_ZERO);
  localparam logic [rsi_pkg::ADDR_W-1:0] ADDR_SPARE     = rsi_pkg::ADDR_W'(4);
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam longint DIST_SAT = (longint'(1) << rsi_pkg::DIST_W) - 1;

  typedef struct packed {
    logic signed [rsi_pkg::POS_W-1:0] origin_x, origin_y, origin_z;
    logic signed [rsi_pkg::DIR_W-1:0] dir_x, dir_y, dir_z;
    logic signed [rsi_pkg::POS_W-1:0] center_x, center_y, center_z;
    logic        [rsi_pkg::RAD_W-1:0] radius;
  } ray_t;

  typedef struct packed {
    logic                       hit;
    logic [rsi_pkg::DIST_W-1:0] distance;
  } hit_t;

  localparam int RAY_W = $bits(ray_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ray_t in_ray = '0;
  logic out_valid, out_ready = 1'b0, out_hit;
  logic [rsi_pkg::DIST_W-1:0] out_hit_distance;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0, cfg_pready;
  logic [rsi_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [rsi_pkg::DATA_W-1:0] cfg_pwdata = '0, cfg_prdata;

  hit_t expected_hits[$];
  logic [rsi_pkg::LIM_W-1:0] limit_model = rsi_pkg::NEAR_ZERO_RESET;
  int tx_idle = 0, rx_idle = 0, rx_hold = 0;
  int mismatches = 0, checked = 0, sent = 0, cycles = 0;

  always #4 clk = ~clk;

  ray_sphere_intersect DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_origin_x(in_ray.origin_x), .in_origin_y(in_ray.origin_y),
    .in_origin_z(in_ray.origin_z),
    .in_dir_x(in_ray.dir_x), .in_dir_y(in_ray.dir_y), .in_dir_z(in_ray.dir_z),
    .in_center_x(in_ray.center_x), .in_center_y(in_ray.center_y),
    .in_center_z(in_ray.center_z), .in_radius(in_ray.radius),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit(out_hit), .out_hit_distance(out_hit_distance),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic hit_t predict_hit(ray_t r, logic [rsi_pkg::LIM_W-1:0] lim);
    longint dx, dy, dz, rad, dsq, rsq, dot, t1, t2sq, dist_calc;
    hit_t res;
    dx = longint'($signed(r.center_x)) - longint'($signed(r.origin_x));
    dy = longint'($signed(r.center_y)) - longint'($signed(r.origin_y));
    dz = longint'($signed(r.center_z)) - longint'($signed(r.origin_z));
    rad = longint'(r.radius);
    dsq = dx * dx + dy * dy + dz * dz;
    rsq = rad * rad;
    res = '0;
    if (dsq < rsq) begin
      res.hit = 1'b1;
      return res;
    end
    dot = dx * longint'($signed(r.dir_x)) + dy * longint'($signed(r.dir_y))
        + dz * longint'($signed(r.dir_z));
    if (dot < 0) return res;
    t1 = dot >>> 14;
    if (t1 < longint'(lim)) return res;
    t2sq = rsq - dsq + t1 * t1;
    if (t2sq < longint'(lim)) return res;
    dist_calc = t1 - longint'(floor_root(t2sq));
    if (dist_calc > DIST_SAT) dist_calc = DIST_SAT;
    res.hit = 1'b1;
    res.distance = dist_calc[rsi_pkg::DIST_W-1:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0d dist=%0d",
                                       out_hit, out_hit_distance);
      end else begin
        hit_t want;
        want = expected_hits.pop_front();
        checked++;
        if (want.hit !== out_hit || want.distance !== out_hit_distance) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d dist=%0d, got hit=%0d dist=%0d",
                     want.hit, want.distance, out_hit, out_hit_distance);
        end
      end
    end
  end

  // receiver with random stalls and the long hold-off
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("ray_sphere_intersect_test: errors");
      $finish;
    end
  end

  task automatic send_ray(ray_t r);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ray <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_hits.push_back(predict_hit(r, limit_model));
    sent++;
  endtask

  // drop valid on the accepting edge of the last transaction, then wait for every expected result
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(logic [rsi_pkg::ADDR_W-1:0] addr,
                             logic [rsi_pkg::DATA_W-1:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_NEAR_ZERO) limit_model = val[rsi_pkg::LIM_W-1:0];
    // read back through the same port
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_paddr <= ADDR_NEAR_ZERO;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[rsi_pkg::LIM_W-1:0] !== limit_model) begin
      mismatches++;
      if (mismatches <= 10) $display("limit readback: expected %0d, got %0d",
                                     limit_model, cfg_prdata[rsi_pkg::LIM_W-1:0]);
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ray_t noise_ray();
    ray_t r;
    r = RAY_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return r;
  endfunction

  // ray aimed roughly at a sphere, with the direction scaled to unit length
  function automatic ray_t aimed_ray();
    ray_t r;
    real vx, vy, vz, norm;
    longint ox, oy, oz, reach, rad, jit;
    vx = real'($urandom_range(32768)) - 16384.0;
    vy = real'($urandom_range(32768)) - 16384.0;
    vz = real'($urandom_range(32768)) - 16384.0;
    norm = $sqrt(vx * vx + vy * vy + vz * vz);
    if (norm < 1.0) begin
      vx = 16384.0;
      norm = 16384.0;
    end
    r.dir_x = rsi_pkg::DIR_W'($rtoi(vx * 16384.0 / norm));
    r.dir_y = rsi_pkg::DIR_W'($rtoi(vy * 16384.0 / norm));
    r.dir_z = rsi_pkg::DIR_W'($rtoi(vz * 16384.0 / norm));
    ox = longint'($urandom_range(1 << 22)) - longint'(1 << 21);
    oy = longint'($urandom_range(1 << 22)) - longint'(1 << 21);
    oz = longint'($urandom_range(1 << 22)) - longint'(1 << 21);
    reach = longint'($urandom_range(0, ($urandom_range(3) == 0) ? (1 << 21) : (1 << 16)));
    rad = longint'($urandom_range(1, ($urandom_range(3) == 0) ? (1 << 20) : (1 << 14)));
    jit = longint'($urandom_range(32'(2 * rad))) - rad;
    r.origin_x = rsi_pkg::POS_W'(ox);
    r.origin_y = rsi_pkg::POS_W'(oy);
    r.origin_z = rsi_pkg::POS_W'(oz);
    r.center_x = rsi_pkg::POS_W'(ox + ((reach * longint'($signed(r.dir_x))) >>> 14) + jit);
    r.center_y = rsi_pkg::POS_W'(oy + ((reach * longint'($signed(r.dir_y))) >>> 14));
    r.center_z = rsi_pkg::POS_W'(oz + ((reach * longint'($signed(r.dir_z))) >>> 14) - jit);
    r.radius = rsi_pkg::RAD_W'(rad);
    return r;
  endfunction

  function automatic ray_t pick_ray();
    ray_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return aimed_ray();
    if (pick < 88) return noise_ray();
    // origin inside, or sitting on the surface
    r = aimed_ray();
    r.center_x = r.origin_x;
    r.center_y = r.origin_y + (((pick & 1) != 0) ? '0 : rsi_pkg::POS_W'(r.radius));
    r.center_z = r.origin_z;
    return r;
  endfunction

  task automatic test_directed();
    ray_t r;
    r = '0;
    r.dir_x = 16'sd16384;
    r.center_x = 24'sd40960;
    r.radius = 23'd4096;
    send_ray(r);                         // straight hit along x
    r.dir_x = -16'sd16384;
    send_ray(r);                         // pointing away
    r.dir_x = 16'sd16384;
    r.center_y = 24'sd8192;
    send_ray(r);                         // passing beside
    r.center_y = 24'sd4096;
    send_ray(r);                         // grazing
    r.center_y = '0;
    r.center_x = 24'sd4096;
    send_ray(r);                         // origin on the surface
    r.radius = 23'd4097;
    send_ray(r);                         // origin just inside
    r.radius = '1;
    send_ray(r);                         // largest radius
    r = '0;
    send_ray(r);                         // zero everything
    r.dir_x = 16'sd16384;
    r.dir_y = 16'sd16384;
    r.dir_z = 16'sd16384;                // non-unit direction
    r.origin_x = 24'sh800000;
    r.origin_y = 24'sh800000;
    r.origin_z = 24'sh800000;
    r.center_x = 24'sh7fffff;
    r.center_y = 24'sh7fffff;
    r.center_z = 24'sh7fffff;
    r.radius = 23'd1;
    send_ray(r);                         // farthest reach
    r.dir_x = -16'sd16384;
    r.dir_y = -16'sd16384;
    r.dir_z = -16'sd16384;
    r.origin_x = 24'sh7fffff;
    r.origin_y = 24'sh7fffff;
    r.origin_z = 24'sh7fffff;
    r.center_x = 24'sh800000;
    r.center_y = 24'sh800000;
    r.center_z = 24'sh800000;
    send_ray(r);
    r.dir_x = 16'sh8000;
    r.dir_y = 16'sh7fff;
    r.dir_z = 16'sh0001;
    send_ray(r);                         // out-of-range direction patterns
    r = '1;
    send_ray(r);
    repeat (6) send_ray(noise_ray());
    wait_idle();
  endtask

  task automatic test_random(int n, int tx_pct, int rx_pct);
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    repeat (n) send_ray(pick_ray());
    wait_idle();
  endtask

  task automatic test_backpressure();
    tx_idle = 0;
    rx_idle = 0;
    @(posedge clk);
    rx_hold = 300;
    repeat (120) send_ray(pick_ray());
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_limit(ADDR_NEAR_ZERO, 32'd0);
    test_directed();
    write_limit(ADDR_SPARE, 32'hffffffff);   // outside the register map, ignored
    write_limit(ADDR_NEAR_ZERO, 32'hffffff00 | 32'd255);
    test_directed();
    test_random(450, 13, 54);
    write_limit(ADDR_NEAR_ZERO, 32'($urandom_range(2, 254)));
    test_random(450, 54, 13);
    write_limit(ADDR_NEAR_ZERO, 32'd1);
    test_random(450, 0, 0);
    test_backpressure();
    $display("%0d rays sent, %0d results checked, limits 0/1/255/random, with", sent, checked);
    $display("idle mixes, a long output stall and %0d mismatches", mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("ray_sphere_intersect_test: clean");
    end else begin
      $display("ray_sphere_intersect_test: errors");
    end
    $finish;
  end

endmodule
